@@ src/iae_pkg.sv @@
// Shared types and constants for the indexed array insert/erase core.
// Command and status codes, default sizes and the result word type.
// No dependencies.
`default_nettype none

package iae_pkg;

	localparam int DEPTH_DEF         = 256;
	localparam int ELEMENT_WIDTH_DEF = 32;

	localparam int CMD_W    = 3;
	localparam int POS_W    = 9;
	localparam int VALUE_W  = 32;
	localparam int RDVAL_W  = 32;
	localparam int COUNT_W  = 9;
	localparam int STATUS_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 3'd0,
		CMD_APPEND = 3'd1,
		CMD_ERASE  = 3'd2,
		CMD_WRITE  = 3'd3,
		CMD_READ   = 3'd4,
		CMD_RESIZE = 3'd5
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		logic [RDVAL_W-1:0] read_value;
		logic [COUNT_W-1:0] entry_count;
		status_t            status;
	} result_t;

endpackage

`default_nettype wire

@@ src/indexed_array_insert_erase_core.sv @@
// Top level of the indexed array insert/erase core.
// Instantiates iae_seq and iae_mem and holds the result word register.
// Depends on iae_pkg.
//
//  channel  signals                                   direction
//  in       in_valid, in_stall, command/position/value  word in
//  out      out_valid, out_stall, read_value/entry_count/status  word out
//
// One command word at a time. Append, write, read, shrink, flagged and
// unused commands need no walk, nor do insert at the end and erase of the
// last entry. Any other insert at index p shifts the entries from p up by one,
// erase at p shifts the entries above p down, resize growing from n to m
// fills entries n to m-1: each walk goes over the store one entry per cycle
// through its single write port.
// Reset clears the count and control; store contents are not cleared.
// A held result waits in the output register while the next word is taken.
`default_nettype none

module indexed_array_insert_erase_core
	import iae_pkg::*;
#(
	parameter int DEPTH         = DEPTH_DEF,
	parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [CMD_W-1:0]    command,
	input  wire logic [POS_W-1:0]    position,
	input  wire logic [VALUE_W-1:0]  value,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic      [RDVAL_W-1:0]  read_value,
	output logic      [COUNT_W-1:0]  entry_count,
	output logic      [STATUS_W-1:0] status
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic                     res_valid;
	result_t                  res;
	logic                     res_take;
	logic                     we, re;
	logic [AW-1:0]            waddr, raddr;
	logic [ELEMENT_WIDTH-1:0] wdata, rdata;
	logic                     out_valid_q;
	result_t                  out_q;

	assign res_take = res_valid && (!out_valid_q || !out_stall);

	iae_seq #(
		.DEPTH (DEPTH),
		.EW    (ELEMENT_WIDTH),
		.AW    (AW),
		.CW    (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (in_valid),
		.cmd_stall (in_stall),
		.command   (command),
		.position  (position),
		.value     (value),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata),
		.re        (re),
		.raddr     (raddr),
		.rdata     (rdata)
	);

	iae_mem #(
		.DEPTH (DEPTH),
		.EW    (ELEMENT_WIDTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = out_q.read_value;
	assign entry_count = out_q.entry_count;
	assign status      = out_q.status;

endmodule

`default_nettype wire

@@ src/iae_mem.sv @@
// Element store: one write port, one read port, registered read data.
// Read data holds while no read is issued.
// Depends on nothing.
`default_nettype none

module iae_mem #(
	parameter int DEPTH = 256,
	parameter int EW    = 32,
	parameter int AW    = 8
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [EW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [EW-1:0] rdata
);

	logic [EW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ src/iae_seq.sv @@
// Command sequencer: decodes a word, keeps the live count and walks the
// store one entry per cycle for shifts and fills.
// Depends on iae_pkg; drives the ports of iae_mem.
`default_nettype none

module iae_seq
	import iae_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int EW    = ELEMENT_WIDTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire logic [CMD_W-1:0]   command,
	input  wire logic [POS_W-1:0]   position,
	input  wire logic [VALUE_W-1:0] value,
	output logic                    res_valid,
	output result_t                 res,
	input  wire logic               res_take,
	output logic                    we,
	output logic      [AW-1:0]      waddr,
	output logic      [EW-1:0]      wdata,
	output logic                    re,
	output logic      [AW-1:0]      raddr,
	input  wire logic [EW-1:0]      rdata
);

	localparam int XW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_UP_RUN   = 8'b0000_0010,
		S_UP_DRAIN = 8'b0000_0100,
		S_PUT      = 8'b0000_1000,
		S_DN_RUN   = 8'b0001_0000,
		S_DN_DRAIN = 8'b0010_0000,
		S_FILL     = 8'b0100_0000,
		S_EMIT     = 8'b1000_0000
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [AW-1:0] lim_q, lim_d;
	logic [EW-1:0] val_q;
	status_t       status_q, status_d;
	logic          rd_ok_q, rd_ok_d;
	logic          wv_s1;
	logic [AW-1:0] waddr_s1;

	logic [XW-1:0] pos_x, cnt_x;
	logic [EW-1:0] val_x;
	logic          accept;

	assign pos_x     = XW'(position);
	assign cnt_x     = XW'(cnt_q);
	assign val_x     = EW'(value);
	assign accept    = cmd_valid && (state_q == S_IDLE);
	assign cmd_stall = (state_q != S_IDLE);

	assign res_valid       = (state_q == S_EMIT);
	assign res.read_value  = rd_ok_q ? RDVAL_W'(rdata) : '0;
	assign res.entry_count = COUNT_W'(cnt_q);
	assign res.status      = status_q;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		ptr_d    = ptr_q;
		lim_d    = lim_q;
		status_d = status_q;
		rd_ok_d  = rd_ok_q;
		we       = 1'b0;
		waddr    = ptr_q;
		wdata    = val_q;
		re       = 1'b0;
		raddr    = ptr_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					status_d = ST_DONE;
					rd_ok_d  = 1'b0;
					state_d  = S_EMIT;
					case (command)
						CMD_INSERT, CMD_APPEND: begin
							if (command == CMD_INSERT && pos_x > cnt_x) begin
								status_d = ST_RANGE;
							end else if (cnt_x == XW'(DEPTH)) begin
								status_d = ST_FULL;
							end else begin
								cnt_d = cnt_q + 1'b1;
								lim_d = (command == CMD_APPEND) ? AW'(cnt_q) : AW'(pos_x);
								if (command == CMD_APPEND || pos_x == cnt_x) begin
									we    = 1'b1;
									waddr = AW'(cnt_q);
									wdata = val_x;
								end else begin
									ptr_d   = AW'(cnt_q - 1'b1);
									state_d = S_UP_RUN;
								end
							end
						end
						CMD_ERASE: begin
							if (pos_x >= cnt_x) begin
								status_d = ST_RANGE;
							end else begin
								cnt_d = cnt_q - 1'b1;
								lim_d = AW'(cnt_q - 1'b1);
								ptr_d = AW'(pos_x + 1'b1);
								if (pos_x + 1'b1 != cnt_x) begin
									state_d = S_DN_RUN;
								end
							end
						end
						CMD_WRITE: begin
							if (pos_x >= cnt_x) begin
								status_d = ST_RANGE;
							end else begin
								we    = 1'b1;
								waddr = AW'(pos_x);
								wdata = val_x;
							end
						end
						CMD_READ: begin
							if (pos_x >= cnt_x) begin
								status_d = ST_RANGE;
							end else begin
								re      = 1'b1;
								raddr   = AW'(pos_x);
								rd_ok_d = 1'b1;
							end
						end
						CMD_RESIZE: begin
							if (pos_x > XW'(DEPTH)) begin
								status_d = ST_FULL;
							end else begin
								cnt_d = CW'(pos_x);
								ptr_d = AW'(cnt_q);
								lim_d = AW'(pos_x - 1'b1);
								if (pos_x > cnt_x) begin
									state_d = S_FILL;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_UP_RUN: begin
				re    = 1'b1;
				raddr = ptr_q;
				we    = wv_s1;
				waddr = waddr_s1;
				wdata = rdata;
				if (ptr_q == lim_q) begin
					state_d = S_UP_DRAIN;
				end else begin
					ptr_d = ptr_q - 1'b1;
				end
			end
			S_UP_DRAIN: begin
				we      = 1'b1;
				waddr   = waddr_s1;
				wdata   = rdata;
				state_d = S_PUT;
			end
			S_PUT: begin
				we      = 1'b1;
				waddr   = lim_q;
				wdata   = val_q;
				state_d = S_EMIT;
			end
			S_DN_RUN: begin
				re    = 1'b1;
				raddr = ptr_q;
				we    = wv_s1;
				waddr = waddr_s1;
				wdata = rdata;
				if (ptr_q == lim_q) begin
					state_d = S_DN_DRAIN;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			S_DN_DRAIN: begin
				we      = 1'b1;
				waddr   = waddr_s1;
				wdata   = rdata;
				state_d = S_EMIT;
			end
			S_FILL: begin
				we    = 1'b1;
				waddr = ptr_q;
				wdata = val_q;
				ptr_d = ptr_q + 1'b1;
				if (ptr_q == lim_q) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			status_q <= ST_DONE;
			rd_ok_q  <= 1'b0;
			wv_s1    <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			status_q <= status_d;
			rd_ok_q  <= rd_ok_d;
			wv_s1    <= (state_q == S_UP_RUN) || (state_q == S_DN_RUN);
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		lim_q <= lim_d;
		if (accept) begin
			val_q <= val_x;
		end
		if (state_q == S_UP_RUN) begin
			waddr_s1 <= ptr_q + 1'b1;
		end else begin
			waddr_s1 <= ptr_q - 1'b1;
		end
	end

endmodule

`default_nettype wire
